/* rtl/core/pdn_pkg.sv */
package pdn_pkg;

  // Sequencer states of the densifier.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SQX,
    ST_SQY,
    ST_SQSUM,
    ST_RMUL,
    ST_RSQ,
    ST_RCMP,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT,
    ST_FINAL
  } pdn_state_e;

  // Register indexes on the configuration port.
  localparam logic [1:0] CFG_SPACING   = 2'd0;
  localparam logic [1:0] CFG_MAX_INTVL = 2'd1;
  localparam logic [1:0] CFG_MAX_POSES = 2'd2;
  localparam logic [1:0] CFG_MAX_PTS   = 2'd3;

  // Run status codes.
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_MANY = 2'd2;
  localparam logic [1:0] STAT_OVF  = 2'd3;

  // Quotient selector for the four divisions of one interval.
  localparam logic [1:0] DIV_X = 2'd0;
  localparam logic [1:0] DIV_Y = 2'd1;
  localparam logic [1:0] DIV_H = 2'd2;
  localparam logic [1:0] DIV_T = 2'd3;

  localparam int unsigned MUL_W  = 20;
  localparam int unsigned DIFF_W = 33;

  // Handshake between sequencer and divider.
  typedef struct packed {
    logic       start;
    logic [4:0] divisor;
  } pdn_div_ctl_t;

endpackage

/* rtl/core/pdn_mul.sv */
module pdn_mul
  import pdn_pkg::*;
(
  input  logic                   clk_i,
  input  logic [MUL_W-1:0]       a_i,
  input  logic [MUL_W-1:0]       b_i,
  output logic [2*MUL_W-1:0]     p_o
);

  logic [2*MUL_W-1:0] p_q;

  // Product is registered so the compare sits in the next cycle.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* rtl/core/pdn_div.sv */
module pdn_div
  import pdn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pdn_div_ctl_t             ctl_i,
  input  logic signed [DIFF_W-1:0] dividend_i,
  output logic                     done_o,
  output logic signed [DIFF_W-1:0] quotient_o
);

  logic [DIFF_W-1:0] quo_q;
  logic [4:0]        rem_q;
  logic [4:0]        dvs_q;
  logic [5:0]        cnt_q;
  logic              neg_q;
  logic              busy_q;
  logic              done_q;
  logic [5:0]        trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle, on magnitudes.
  assign trial = {rem_q, quo_q[DIFF_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(DIFF_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      neg_q <= dividend_i[DIFF_W-1];
      quo_q <= dividend_i[DIFF_W-1] ? DIFF_W'(-dividend_i) : dividend_i;
      rem_q <= '0;
      dvs_q <= ctl_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? 5'(trial - {1'b0, dvs_q}) : trial[4:0];
      quo_q <= {quo_q[DIFF_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? DIFF_W'(-quo_q) : quo_q;

endmodule

/* rtl/core/pose_path_densifier_top.sv */
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+-----------------------------------------
// input    | in_valid_i / in_ready_o         | pos_x_i .. end_of_lane_i, one pose
// output   | out_valid_o / out_ready_i       | out_x_o .. status_o, one point or result
// config   | cfg_we_i (no wait)              | cfg_addr_i, cfg_data_i
//
// A pose that is not interpolated (first pose of a lane, too many poses, or a
// lane that already overflowed) passes only through the idle, decide and final
// states. An interval whose search finds no point counts the cap c down to zero
// and then goes to the final state. A pose that generates n points runs the
// distance search on the shared multiplier (skipped for a far interval), then
// the four quotients on the bit-serial divider, then sends the n points, so
// the serial divider takes most of its time.
// Reset clears configuration to its defaults and the lane state at once.
// A stalled output only holds the sequencer when it has a new result to load.
module pose_path_densifier_top
  import pdn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] trailer_angle_i,
  input  logic signed [15:0] speed_i,
  input  logic signed [15:0] steer_i,
  input  logic [2:0]         trailer_count_i,
  input  logic               end_of_lane_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [15:0] out_heading_o,
  output logic signed [15:0] out_trailer_angle_o,
  output logic signed [15:0] out_speed_o,
  output logic signed [15:0] out_steer_o,
  output logic [2:0]         out_trailer_count_o,
  output logic               run_end_o,
  output logic [1:0]         status_o
);

  // Configuration registers.
  logic [15:0] spacing_q;
  logic [4:0]  max_intvl_q;
  logic [9:0]  max_poses_q;
  logic [11:0] max_pts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q   <= 16'd102;
      max_intvl_q <= 5'd10;
      max_poses_q <= 10'd500;
      max_pts_q   <= 12'd1000;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SPACING:   spacing_q   <= cfg_data_i;
        CFG_MAX_INTVL: max_intvl_q <= cfg_data_i[4:0];
        CFG_MAX_POSES: max_poses_q <= cfg_data_i[9:0];
        CFG_MAX_PTS:   max_pts_q   <= cfg_data_i[11:0];
        default:       ;
      endcase
    end
  end

  // A zero spacing acts as one, and the interval cap is clamped to 1..16.
  logic [15:0] spacing_eff;
  logic [4:0]  cap_eff;
  assign spacing_eff = (spacing_q == 16'd0) ? 16'd1 : spacing_q;
  always_comb begin
    if (max_intvl_q == 5'd0) begin
      cap_eff = 5'd1;
    end else if (max_intvl_q > 5'd16) begin
      cap_eff = 5'd16;
    end else begin
      cap_eff = max_intvl_q;
    end
  end

  pdn_state_e state_q, state_d;

  // Current pose and the stored previous pose.
  logic signed [31:0] cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic signed [15:0] cur_h_q, cur_t_q, cur_sp_q, cur_st_q;
  logic signed [15:0] prev_h_q, prev_t_q, prev_sp_q, prev_st_q;
  logic [2:0]         cur_tc_q, prev_tc_q;
  logic               cur_end_q;

  logic        have_prev_q;
  logic [9:0]  pose_cnt_q;
  logic [12:0] point_cnt_q;
  logic        ovf_q;
  logic        too_many_q;

  logic [4:0]  n_q;
  logic [4:0]  i_q;
  logic [1:0]  sel_q;
  logic [40:0] d2_q;

  logic signed [31:0] acc_x_q, acc_y_q, del_x_q, del_y_q;
  logic signed [15:0] acc_h_q, acc_t_q, del_h_q, del_t_q;

  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // Differences of the interval; angles wrap to 16 bits.
  logic signed [DIFF_W-1:0] dx, dy;
  logic [DIFF_W-1:0]        abs_dx, abs_dy;
  logic signed [15:0]       dh, dt;
  logic                     far, gen;
  assign dx     = {cur_x_q[31], cur_x_q} - {prev_x_q[31], prev_x_q};
  assign dy     = {cur_y_q[31], cur_y_q} - {prev_y_q[31], prev_y_q};
  assign abs_dx = dx[DIFF_W-1] ? DIFF_W'(-dx) : dx;
  assign abs_dy = dy[DIFF_W-1] ? DIFF_W'(-dy) : dy;
  assign dh     = cur_h_q - prev_h_q;
  assign dt     = cur_t_q - prev_t_q;
  // Beyond one kilometre on either axis the cap applies without a search.
  assign far    = (|abs_dx[DIFF_W-1:MUL_W]) || (|abs_dy[DIFF_W-1:MUL_W]);
  assign gen    = have_prev_q && !ovf_q && !too_many_q;

  // Shared multiplier: squares of the differences, then n*spacing and its square.
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  pdn_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(prod));

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQX: begin
        mul_a = abs_dx[MUL_W-1:0];
        mul_b = abs_dx[MUL_W-1:0];
      end
      ST_SQY: begin
        mul_a = abs_dy[MUL_W-1:0];
        mul_b = abs_dy[MUL_W-1:0];
      end
      ST_RMUL: begin
        mul_a = MUL_W'(n_q);
        mul_b = MUL_W'(spacing_eff);
      end
      ST_RSQ: begin
        mul_a = prod[MUL_W-1:0];
        mul_b = prod[MUL_W-1:0];
      end
      default: ;
    endcase
  end

  // Serial divider for the four steps of the interval.
  pdn_div_ctl_t             div_ctl;
  logic signed [DIFF_W-1:0] div_arg;
  logic                     div_done;
  logic signed [DIFF_W-1:0] div_q;
  pdn_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctl_i(div_ctl),
    .dividend_i(div_arg), .done_o(div_done), .quotient_o(div_q)
  );

  always_comb begin
    div_ctl.start   = (state_q == ST_DSTART);
    div_ctl.divisor = n_q;
    unique case (sel_q)
      DIV_X:   div_arg = dx;
      DIV_Y:   div_arg = dy;
      DIV_H:   div_arg = DIFF_W'(dh);
      default: div_arg = DIFF_W'(dt);
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (!gen) begin
          state_d = ST_FINAL;
        end else if (far) begin
          state_d = ST_DSTART;
        end else begin
          state_d = ST_SQX;
        end
      end
      ST_SQX:    state_d = ST_SQY;
      ST_SQY:    state_d = ST_SQSUM;
      ST_SQSUM:  state_d = ST_RMUL;
      ST_RMUL:   state_d = (n_q == 5'd0) ? ST_FINAL : ST_RSQ;
      ST_RSQ:    state_d = ST_RCMP;
      ST_RCMP:   state_d = ({1'b0, prod} <= d2_q) ? ST_DSTART : ST_RMUL;
      ST_DSTART: state_d = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_d = (sel_q == DIV_T) ? ST_EMIT : ST_DSTART;
      ST_EMIT:   if (out_free && i_q == n_q - 5'd1) state_d = ST_FINAL;
      ST_FINAL:  if (!cur_end_q || out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Point count after this interval, saturating at 8191.
  logic [13:0] pc_sum;
  logic [12:0] pc_new;
  assign pc_sum = {1'b0, point_cnt_q} + 14'(n_q);
  assign pc_new = pc_sum[13] ? 13'h1FFF : pc_sum[12:0];

  logic [1:0] fin_status;
  always_comb begin
    priority if (pose_cnt_q < 10'd2) begin
      fin_status = STAT_FEW;
    end else if (too_many_q) begin
      fin_status = STAT_MANY;
    end else if (ovf_q) begin
      fin_status = STAT_OVF;
    end else begin
      fin_status = STAT_OK;
    end
  end

  logic [9:0] pose_inc;
  assign pose_inc = (pose_cnt_q == 10'h3FF) ? pose_cnt_q : pose_cnt_q + 10'd1;

  logic emit_load, fin_load, lane_done;
  assign emit_load = (state_q == ST_EMIT) && out_free;
  assign fin_load  = (state_q == ST_FINAL) && cur_end_q && out_free;
  assign lane_done = fin_load;

  // Lane control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      pose_cnt_q  <= '0;
      point_cnt_q <= '0;
      ovf_q       <= 1'b0;
      too_many_q  <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      sel_q       <= DIV_X;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_IDLE && in_valid_i) begin
        pose_cnt_q <= pose_inc;
        too_many_q <= pose_inc >= max_poses_q;
      end
      if (state_q == ST_DECIDE) begin
        n_q   <= cap_eff;
        sel_q <= DIV_X;
      end
      if (state_q == ST_RCMP && !({1'b0, prod} <= d2_q)) n_q <= n_q - 5'd1;
      if (state_q == ST_DWAIT && div_done) begin
        sel_q <= sel_q + 2'd1;
        i_q   <= '0;
      end
      if (emit_load) begin
        i_q <= i_q + 5'd1;
        if (i_q == n_q - 5'd1) begin
          point_cnt_q <= pc_new;
          if (pc_new > {1'b0, max_pts_q}) ovf_q <= 1'b1;
        end
      end
      if (state_q == ST_FINAL && !cur_end_q) have_prev_q <= 1'b1;
      if (lane_done) begin
        have_prev_q <= 1'b0;
        pose_cnt_q  <= '0;
        point_cnt_q <= '0;
        ovf_q       <= 1'b0;
      end
      if (emit_load || fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pose data, sums and the output register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cur_x_q   <= pos_x_i;
      cur_y_q   <= pos_y_i;
      cur_h_q   <= heading_i;
      cur_t_q   <= trailer_angle_i;
      cur_sp_q  <= speed_i;
      cur_st_q  <= steer_i;
      cur_tc_q  <= trailer_count_i;
      cur_end_q <= end_of_lane_i;
    end
    if (state_q == ST_SQY) d2_q <= 41'(prod);
    if (state_q == ST_SQSUM) d2_q <= d2_q + 41'(prod);
    if (state_q == ST_DWAIT && div_done) begin
      unique case (sel_q)
        DIV_X:   del_x_q <= div_q[31:0];
        DIV_Y:   del_y_q <= div_q[31:0];
        DIV_H:   del_h_q <= div_q[15:0];
        default: del_t_q <= div_q[15:0];
      endcase
      acc_x_q <= prev_x_q;
      acc_y_q <= prev_y_q;
      acc_h_q <= prev_h_q;
      acc_t_q <= prev_t_q;
    end
    if (emit_load) begin
      out_x_o             <= acc_x_q;
      out_y_o             <= acc_y_q;
      out_heading_o       <= acc_h_q;
      out_trailer_angle_o <= acc_t_q;
      out_speed_o         <= prev_sp_q;
      out_steer_o         <= prev_st_q;
      out_trailer_count_o <= prev_tc_q;
      run_end_o           <= 1'b0;
      status_o            <= STAT_OK;
      acc_x_q <= acc_x_q + del_x_q;
      acc_y_q <= acc_y_q + del_y_q;
      acc_h_q <= acc_h_q + del_h_q;
      acc_t_q <= acc_t_q + del_t_q;
    end
    if (fin_load) begin
      // A failed lane reports its status with every pose field cleared.
      if (fin_status == STAT_OK) begin
        out_x_o             <= cur_x_q;
        out_y_o             <= cur_y_q;
        out_heading_o       <= cur_h_q;
        out_trailer_angle_o <= cur_t_q;
        out_speed_o         <= cur_sp_q;
        out_steer_o         <= cur_st_q;
        out_trailer_count_o <= cur_tc_q;
      end else begin
        out_x_o             <= '0;
        out_y_o             <= '0;
        out_heading_o       <= '0;
        out_trailer_angle_o <= '0;
        out_speed_o         <= '0;
        out_steer_o         <= '0;
        out_trailer_count_o <= '0;
      end
      run_end_o <= 1'b1;
      status_o  <= fin_status;
    end
    if (state_q == ST_FINAL) begin
      prev_x_q  <= cur_x_q;
      prev_y_q  <= cur_y_q;
      prev_h_q  <= cur_h_q;
      prev_t_q  <= cur_t_q;
      prev_sp_q <= cur_sp_q;
      prev_st_q <= cur_st_q;
      prev_tc_q <= cur_tc_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // The divider only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DWAIT)
    else $error("divider finished outside its wait state");

  // Points are only sent for a nonzero count within the cap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> (n_q != 5'd0 && n_q <= 5'd16 && i_q < n_q))
    else $error("point counter out of range");

  // A failed lane ends with a run-end result and a cleared x position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != STAT_OK) |-> (run_end_o && out_x_o == 32'sd0))
    else $error("error result carries pose data");

endmodule
